// File: rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int unsigned IdW     = 16;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ClampW  = 5;

  localparam logic OpArrive = 1'b0;
  localparam logic OpPop    = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctrl_t;

endpackage

// File: rtl/core/spq_cell.sv
module spq_cell #(
  parameter int unsigned LvW  = 3,
  parameter int unsigned IdSW = 16
) (
  input  logic              clk_i,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic              occ_i,
  input  logic [LvW-1:0]    new_level_i,
  input  logic [IdSW-1:0]   new_id_i,
  input  logic              prev_behind_i,
  input  logic [LvW-1:0]    prev_level_i,
  input  logic [IdSW-1:0]   prev_id_i,
  input  logic [LvW-1:0]    next_level_i,
  input  logic [IdSW-1:0]   next_id_i,
  output logic              behind_o,
  output logic [LvW-1:0]    level_o,
  output logic [IdSW-1:0]   id_o
);
  import spq_pkg::*;

  logic [LvW-1:0]  level_q, level_d;
  logic [IdSW-1:0] id_q, id_d;

  assign behind_o = occ_i && (level_q <= new_level_i);

  always_comb begin
    level_d = level_q;
    id_d    = id_q;
    if (ctrl_i.push) begin
      if (!prev_behind_i) begin
        level_d = prev_level_i;
        id_d    = prev_id_i;
      end else if (!behind_o) begin
        level_d = new_level_i;
        id_d    = new_id_i;
      end
    end else if (ctrl_i.pop) begin
      level_d = next_level_i;
      id_d    = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    id_q    <= id_d;
  end

  assign level_o = level_q;
  assign id_o    = id_q;

endmodule

// File: rtl/core/stable_priority_queue_core.sv
// Stable priority queue held in a chain of CAPACITY cells, kept sorted with the head in the
// first cell. An arrive beat with a level from 1 (most urgent) to LEVELS is placed behind every
// waiting entry of the same or a more urgent level; levels outside that range are saturated.
// A pop beat returns the head identifier with status ok, or status empty on an empty queue; an
// arrival on a full queue is dropped with status full. Accepted arrivals give no result beat.
// Every operation completes through a parallel compare and shift across all cells, so one
// beat is taken per cycle while input is not stalled; a result beat appears in the output
// register in the cycle after its input beat, and input is stalled only while that
// register is held by output stall. No clearing pass is needed after reset.
module stable_priority_queue_core #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned LEVELS   = 5,
  parameter int unsigned ID_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic [spq_pkg::IdW-1:0]    item_id_i,
  input  logic [spq_pkg::LevelW-1:0] level_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [spq_pkg::IdW-1:0]    served_id_o,
  output logic [spq_pkg::StatusW-1:0] status_o
);
  import spq_pkg::*;

  localparam int unsigned LvW  = $clog2(LEVELS + 1);
  localparam int unsigned IdSW = (ID_BITS < IdW) ? ID_BITS : IdW;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] occ_q, occ_d;
  logic            out_valid_q, out_valid_d;
  logic [IdW-1:0]  served_id_q;
  spq_status_e     status_q;

  logic            accept, is_arrive, full, empty, has_result;
  spq_ctrl_t       ctrl;
  logic [ClampW-1:0] lv_ext;
  logic [LvW-1:0]  new_level;
  logic [IdSW-1:0] new_id;

  logic [LvW-1:0]  cell_level [CAPACITY];
  logic [IdSW-1:0] cell_id    [CAPACITY];
  logic            cell_behind[CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_arrive  = (op_i == OpArrive);
  assign full       = (occ_q == CntW'(CAPACITY));
  assign empty      = (occ_q == '0);
  assign has_result = accept && (!is_arrive || full);

  assign ctrl.push = accept && is_arrive && !full;
  assign ctrl.pop  = accept && !is_arrive && !empty;

  always_comb begin
    lv_ext = ClampW'(level_i);
    if (lv_ext == '0) begin
      lv_ext = ClampW'(1);
    end else if (lv_ext > ClampW'(LEVELS)) begin
      lv_ext = ClampW'(LEVELS);
    end
  end

  assign new_level = lv_ext[LvW-1:0];
  assign new_id    = item_id_i[IdSW-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            prev_behind;
    logic [LvW-1:0]  prev_level, next_level;
    logic [IdSW-1:0] prev_id, next_id;

    if (i == 0) begin : g_first
      assign prev_behind = 1'b1;
      assign prev_level  = new_level;
      assign prev_id     = new_id;
    end else begin : g_mid
      assign prev_behind = cell_behind[i-1];
      assign prev_level  = cell_level[i-1];
      assign prev_id     = cell_id[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_level = cell_level[i];
      assign next_id    = cell_id[i];
    end else begin : g_inner
      assign next_level = cell_level[i+1];
      assign next_id    = cell_id[i+1];
    end

    spq_cell #(
      .LvW  (LvW),
      .IdSW (IdSW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (occ_q > CntW'(i)),
      .new_level_i   (new_level),
      .new_id_i      (new_id),
      .prev_behind_i (prev_behind),
      .prev_level_i  (prev_level),
      .prev_id_i     (prev_id),
      .next_level_i  (next_level),
      .next_id_i     (next_id),
      .behind_o      (cell_behind[i]),
      .level_o       (cell_level[i]),
      .id_o          (cell_id[i])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (ctrl.push) begin
      occ_d = occ_q + CntW'(1);
    end else if (ctrl.pop) begin
      occ_d = occ_q - CntW'(1);
    end
    out_valid_d = out_valid_q;
    if (has_result) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result) begin
      if (is_arrive) begin
        served_id_q <= '0;
        status_q    <= StFull;
      end else if (empty) begin
        served_id_q <= '0;
        status_q    <= StEmpty;
      end else begin
        served_id_q <= IdW'(cell_id[0]);
        status_q    <= StOk;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign served_id_o = served_id_q;
  assign status_o    = status_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> (occ_q == $past(occ_q) + CntW'(1)))
    else $error("insertion did not raise occupancy");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_arrive && full) |=> (out_valid_o && status_o == StFull && occ_q == $past(occ_q)))
    else $error("arrival on full queue not reported as dropped");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q >= CntW'(2)) |-> (cell_level[0] <= cell_level[1]))
    else $error("head cells out of order");

endmodule

// File: verif/spq_order_checker.sv
module spq_order_checker #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned LEVELS   = 5,
  parameter int unsigned ID_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        op_i,
  input  logic [spq_pkg::IdW-1:0]     item_id_i,
  input  logic [spq_pkg::LevelW-1:0]  level_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [spq_pkg::IdW-1:0]     served_id_i,
  input  logic [spq_pkg::StatusW-1:0] status_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import spq_pkg::*;

  typedef struct packed {
    logic [IdW-1:0] served_id;
    spq_status_e    status;
  } service_t;

  logic [LevelW-1:0] held_level [CAPACITY];
  logic [IdW-1:0]    held_ident [CAPACITY];
  int unsigned       held_count;
  int unsigned       mismatches;
  service_t          due_services [$];

  // Entries are kept head first; an arrival goes behind every entry of equal or more urgent level.
  task automatic predict_service(input logic op, input logic [IdW-1:0] ident,
                                 input logic [LevelW-1:0] raw_level);
    logic [63:0]       id_mask;
    logic [LevelW-1:0] lvl;
    int unsigned       slot;
    id_mask = (64'd1 << ID_BITS) - 64'd1;
    lvl = raw_level;
    if (raw_level == '0) begin
      lvl = LevelW'(1);
    end else if (raw_level > LEVELS) begin
      lvl = LevelW'(LEVELS);
    end
    if (op == OpArrive) begin
      if (held_count >= CAPACITY) begin
        due_services.push_back('{served_id: '0, status: StFull});
      end else begin
        slot = 0;
        while (slot < held_count && held_level[slot] <= lvl) slot++;
        for (int unsigned k = held_count; k > slot; k--) begin
          held_level[k] = held_level[k-1];
          held_ident[k] = held_ident[k-1];
        end
        held_level[slot] = lvl;
        held_ident[slot] = ident & id_mask[IdW-1:0];
        held_count++;
      end
    end else if (held_count == 0) begin
      due_services.push_back('{served_id: '0, status: StEmpty});
    end else begin
      due_services.push_back('{served_id: held_ident[0], status: StOk});
      for (int unsigned k = 1; k < held_count; k++) begin
        held_level[k-1] = held_level[k];
        held_ident[k-1] = held_ident[k];
      end
      held_count--;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    service_t want;
    if (!rst_ni) begin
      held_count = 0;
      mismatches = 0;
      due_services.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // A result beat always belongs to an earlier input beat, so it is checked first.
      if (out_valid_i && !out_stall_i) begin
        if (due_services.size() == 0) begin
          $error("unexpected result beat: served_id %h, status %0d", served_id_i, status_i);
          mismatches++;
        end else begin
          want = due_services.pop_front();
          if (served_id_i !== want.served_id) begin
            $error("served_id mismatch: expected %h, actual %h", want.served_id, served_id_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_service(op_i, item_id_i, level_i);
      end
      pending_o <= due_services.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  import spq_pkg::*;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned Levels    = 5;
  localparam int unsigned IdBits    = 16;
  localparam int unsigned BeatTotal = 630;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               op_i;
  logic [IdW-1:0]     item_id_i;
  logic [LevelW-1:0]  level_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IdW-1:0]     served_id_o;
  logic [StatusW-1:0] status_o;
  int unsigned        fail_count;
  int unsigned        pending;

  int unsigned beats_sent;
  int unsigned burst_left;
  int          queued;

  stable_priority_queue_core #(
    .CAPACITY (Capacity),
    .LEVELS   (Levels),
    .ID_BITS  (IdBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .item_id_i   (item_id_i),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .served_id_o (served_id_o),
    .status_o    (status_o)
  );

  spq_order_checker #(
    .CAPACITY (Capacity),
    .LEVELS   (Levels),
    .ID_BITS  (IdBits)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .op_i         (op_i),
    .item_id_i    (item_id_i),
    .level_i      (level_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .served_id_i  (served_id_o),
    .status_i     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [LevelW-1:0] pick_level();
    if ($urandom_range(0, 7) == 0) begin
      return LevelW'($urandom_range(0, 7));
    end
    return LevelW'($urandom_range(1, Levels));
  endfunction

  // The sender works in bursts; valid is only lowered once a burst has run out.
  task automatic offer_beat(input logic op, input logic [IdW-1:0] ident,
                            input logic [LevelW-1:0] lvl);
    in_valid_i <= 1'b1;
    op_i <= op;
    item_id_i <= ident;
    level_i <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (op == OpArrive && queued < Capacity) begin
      queued++;
    end else if (op == OpPop && queued > 0) begin
      queued--;
    end
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int unsigned rx_cycles;
    int unsigned mode;
    out_stall_i <= 1'b0;
    rx_cycles = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(8, 50)) begin
        @(posedge clk_i);
        rx_cycles++;
        // A long hold-off keeps a result beat in the output register and so stalls the block's input.
        if (rx_cycles >= 300 && rx_cycles < 450) begin
          out_stall_i <= 1'b1;
        end else begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= $urandom_range(0, 1);
            default: out_stall_i <= ($urandom_range(0, 9) != 0);
          endcase
        end
      end
    end
  end

  initial begin
    int unsigned runs;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    op_i <= OpArrive;
    item_id_i <= '0;
    level_i <= '0;
    beats_sent = 0;
    burst_left = $urandom_range(1, 20);
    queued = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_beat(OpPop, 16'hFFFF, 3'd7);
    offer_beat(OpArrive, 16'h0000, 3'd5);
    offer_beat(OpArrive, 16'hFFFF, 3'd0);
    offer_beat(OpArrive, 16'h1234, 3'd7);
    offer_beat(OpArrive, 16'hAAAA, 3'd1);
    offer_beat(OpArrive, 16'h5555, 3'd3);
    offer_beat(OpArrive, 16'h0F0F, 3'd6);
    offer_beat(OpArrive, 16'hF0F0, 3'd2);
    offer_beat(OpArrive, 16'h0001, 3'd3);
    offer_beat(OpArrive, 16'h8000, 3'd4);
    repeat (10) offer_beat(OpPop, 16'h0000, 3'd0);

    while (beats_sent < BeatTotal) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          runs = Capacity + 4 - queued + $urandom_range(0, 3);
          repeat (runs) offer_beat(OpArrive, IdW'($urandom), pick_level());
        end
        2, 3: begin
          runs = queued + $urandom_range(0, 2);
          repeat (runs) offer_beat(OpPop, IdW'($urandom), LevelW'($urandom));
        end
        default: begin
          repeat ($urandom_range(5, 30)) begin
            offer_beat($urandom_range(0, 1) ? OpPop : OpArrive, IdW'($urandom), pick_level());
          end
        end
      endcase
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_core.sv
verif/spq_order_checker.sv
verif/tb_top.sv
